// ===== rtl/pic_pkg.sv =====
// Shared types and constants of the platform interrupt controller.
package pic_pkg;

	localparam int unsigned NUM_SOURCES_DEF  = 64;
	localparam int unsigned NUM_CONTEXTS_DEF = 2;

	typedef enum logic [1:0] {
		MODE_READ  = 2'd0,
		MODE_WRITE = 2'd1,
		MODE_RAISE = 2'd2,
		MODE_EVAL  = 2'd3
	} mode_t;

	localparam logic [3:0]  ACCESS_BYTES  = 4'd4;
	localparam logic [31:0] ADDR_LIMIT    = 32'h0400_0000;
	localparam logic [31:0] PEND_BASE     = 32'h0000_1000;
	localparam logic [31:0] EN_BASE       = 32'h0000_2000;
	localparam logic [31:0] EN_STRIDE     = 32'h0000_0080;
	localparam logic [19:0] CTX_PAGE_BASE = 20'h00200;
	localparam logic [11:0] THR_OFF       = 12'h000;
	localparam logic [11:0] CLAIM_OFF     = 12'h004;

	// Per-source flags handed to the scan unit for the source it is comparing.
	typedef struct packed {
		logic claimed;
		logic enabled;
		logic pending;
	} scan_bits_t;

	typedef struct packed {
		logic done;
		logic clr_pend;
	} scan_stat_t;

endpackage

// ===== rtl/pic_if.sv =====
// Request and response channel interfaces of the interrupt controller.
interface pic_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [31:0] address;
	logic [3:0]  access_width;
	logic [31:0] write_data;
	logic [5:0]  source_id;
	logic        context_id;

	modport source (output valid, mode, address, access_width, write_data, source_id,
		context_id, input ready);
	modport sink (input valid, mode, address, access_width, write_data, source_id,
		context_id, output ready);
endinterface

interface pic_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_data;
	logic        status;
	logic        interrupt_out;

	modport source (output valid, read_data, status, interrupt_out, input ready);
	modport sink (input valid, read_data, status, interrupt_out, output ready);
endinterface

// ===== rtl/pic_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pic_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/pic_scan.sv =====
// Priority scan unit: walks all sources once, one compare per cycle.
module pic_scan #(
	parameter int unsigned NUM_SOURCES = pic_pkg::NUM_SOURCES_DEF,
	localparam int unsigned IDX_W = $clog2(NUM_SOURCES)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [31:0]         threshold,
	input  logic [31:0]         prio,
	input  pic_pkg::scan_bits_t bits,
	output logic [IDX_W-1:0]    ram_addr,
	output logic [IDX_W-1:0]    idx,
	output pic_pkg::scan_stat_t stat,
	output logic [IDX_W-1:0]    best
);

	localparam int unsigned CNT_W = $clog2(NUM_SOURCES + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic             vld_s1;
	logic             done_q;
	logic [IDX_W-1:0] idx_s1;
	logic [IDX_W-1:0] best_q;
	logic [31:0]      high_q;
	logic             take;
	logic             last_issue;

	assign last_issue = (cnt_q == CNT_W'(NUM_SOURCES - 1));
	// Equal priority replaces the earlier pick, so ties go to the higher index.
	assign take = vld_s1 && !bits.claimed && bits.enabled && bits.pending &&
		(prio >= high_q) && (prio >= threshold);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			vld_s1 <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			vld_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= busy_q;
			done_q <= vld_s1 && (idx_s1 == IDX_W'(NUM_SOURCES - 1));
			if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last_issue) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			best_q <= '0;
			high_q <= '0;
		end else if (take) begin
			best_q <= idx_s1;
			high_q <= prio;
		end
		idx_s1 <= cnt_q[IDX_W-1:0];
	end

	assign ram_addr      = cnt_q[IDX_W-1:0];
	assign idx           = idx_s1;
	assign stat.clr_pend = vld_s1 && bits.claimed;
	assign stat.done     = done_q;
	assign best          = best_q;

endmodule

// ===== rtl/platform_interrupt_controller.sv =====
// Top level of the platform interrupt controller.
// The req channel carries one request per handshake: a bus read, a bus write,
// a raise of an interrupt source, or an evaluation of one context. The rsp
// channel returns exactly one response per request (read_data, status,
// interrupt_out). Both use valid/ready; a request is taken when both are high.
// One request is worked on at a time and req.ready is high only while idle.
// Most requests pass through the states EXEC and DONE; a read of a priority
// register also passes through PRIO (one read of the priority RAM), and an
// evaluation through SCAN: the scan unit reads one priority from the RAM
// and makes one compare per source per cycle.
// A finished response waits in an output register, so the next request is
// taken while the receiver stalls; a second response waits in the sequencer
// until the output register frees up.
// After reset the pending, enable, claim and threshold state is zero; the
// priority RAM is cleared over all entries, during which req.ready stays low.
module platform_interrupt_controller #(
	parameter int unsigned NUM_SOURCES  = pic_pkg::NUM_SOURCES_DEF,
	parameter int unsigned NUM_CONTEXTS = pic_pkg::NUM_CONTEXTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	pic_req_if.sink     req,
	pic_rsp_if.source   rsp
);

	localparam int unsigned IDX_W = $clog2(NUM_SOURCES);
	localparam int unsigned SW    = NUM_SOURCES / 32;
	localparam int unsigned WW    = (SW > 1) ? $clog2(SW) : 1;
	localparam int unsigned CTX_W = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
	localparam int unsigned CNT_W = $clog2(NUM_SOURCES + 1);

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_EXEC  = 6'b000100,
		ST_PRIO  = 6'b001000,
		ST_SCAN  = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] clr_cnt_q;

	// Latched request.
	logic [1:0]  mode_q;
	logic [31:0] addr_q;
	logic [3:0]  width_q;
	logic [31:0] data_q;
	logic [5:0]  src_q;
	logic        ctxin_q;

	// Architectural state.
	logic [NUM_SOURCES-1:0]                    pend_q;
	logic [NUM_CONTEXTS-1:0][NUM_SOURCES-1:0]  en_q;
	logic [NUM_CONTEXTS-1:0][NUM_SOURCES-1:0]  claimed_q;
	logic [NUM_CONTEXTS-1:0][31:0]             thr_q;
	logic [NUM_CONTEXTS-1:0][31:0]             claim_q;

	// Result of the current request and the output register.
	logic [31:0] res_rd_q;
	logic        res_st_q;
	logic        res_irq_q;
	logic        out_vld_q;
	logic [31:0] out_rd_q;
	logic        out_st_q;
	logic        out_irq_q;

	// Decode.
	logic             bad_acc;
	logic             hit_prio;
	logic             hit_pend;
	logic             hit_en;
	logic             hit_pg;
	logic             hit_thr;
	logic             hit_claim;
	logic [31:0]      pend_off;
	logic [31:0]      en_off;
	logic [IDX_W-1:0] prio_idx;
	logic [WW-1:0]    pend_w;
	logic [WW-1:0]    en_w;
	logic [CTX_W-1:0] en_ctx;
	logic [CTX_W-1:0] pg_ctx;
	logic [CTX_W-1:0] ev_ctx;
	logic             ctx_ok;
	logic [31:0]      pend_mask;
	logic [31:0]      en_mask;
	logic             src_ok;
	logic [IDX_W-1:0] src_i;
	logic             claimed_any;
	logic             raise_bad;
	logic [31:0]      cv;
	logic             cv_ok;
	logic             d_ok;
	logic             is_read;
	logic             out_free;

	// RAM and scan unit.
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [31:0]      ram_wdata;
	logic [IDX_W-1:0] ram_raddr;
	logic [31:0]      ram_rdata;
	logic             scan_start;
	logic [IDX_W-1:0] scan_addr;
	logic [IDX_W-1:0] scan_idx;
	logic [IDX_W-1:0] scan_best;
	pic_pkg::scan_bits_t scan_bits;
	pic_pkg::scan_stat_t scan_stat;

	assign is_read  = (mode_q == pic_pkg::MODE_READ);
	assign bad_acc  = (width_q != pic_pkg::ACCESS_BYTES) || (addr_q >= pic_pkg::ADDR_LIMIT);
	assign hit_prio = addr_q < 32'(NUM_SOURCES * 4);
	assign pend_off = addr_q - pic_pkg::PEND_BASE;
	assign hit_pend = (addr_q >= pic_pkg::PEND_BASE) &&
		(addr_q < pic_pkg::PEND_BASE + 32'(NUM_SOURCES / 8));
	assign en_off   = addr_q - pic_pkg::EN_BASE;
	assign hit_en   = (addr_q >= pic_pkg::EN_BASE) &&
		(addr_q < pic_pkg::EN_BASE + pic_pkg::EN_STRIDE * 32'(NUM_CONTEXTS)) &&
		({25'd0, en_off[6:0]} < 32'(NUM_SOURCES / 8));
	assign hit_pg   = (addr_q[31:12] >= pic_pkg::CTX_PAGE_BASE) &&
		(addr_q[31:12] < pic_pkg::CTX_PAGE_BASE + 20'(NUM_CONTEXTS));
	assign hit_thr   = hit_pg && (addr_q[11:0] == pic_pkg::THR_OFF);
	assign hit_claim = hit_pg && (addr_q[11:0] == pic_pkg::CLAIM_OFF);

	assign prio_idx = addr_q[2 +: IDX_W];
	assign pend_w   = pend_off[2 +: WW];
	assign en_w     = en_off[2 +: WW];
	assign en_ctx   = en_off[7 +: CTX_W];
	assign pg_ctx   = addr_q[12 +: CTX_W];
	assign ev_ctx   = CTX_W'(ctxin_q);
	assign ctx_ok   = 32'(ctxin_q) < 32'(NUM_CONTEXTS);

	// Bit 0 of word 0 belongs to source zero and ignores writes.
	assign pend_mask = (pend_w == '0) ? ~32'h1 : '1;
	assign en_mask   = (en_w == '0) ? ~32'h1 : '1;

	assign src_ok = (src_q != 6'd0) && (32'(src_q) < 32'(NUM_SOURCES));
	assign src_i  = IDX_W'(src_q);

	always_comb begin
		claimed_any = 1'b0;
		for (int c = 0; c < NUM_CONTEXTS; c++) begin
			claimed_any = claimed_any | claimed_q[c][src_i];
		end
	end

	assign raise_bad = !src_ok || pend_q[src_i] || claimed_any;
	assign cv        = claim_q[pg_ctx];
	assign cv_ok     = cv < 32'(NUM_SOURCES);
	assign d_ok      = data_q < 32'(NUM_SOURCES);
	assign out_free  = !out_vld_q || rsp.ready;

	assign ram_we = (state_q == ST_CLEAR) ||
		((state_q == ST_EXEC) && (mode_q == pic_pkg::MODE_WRITE) && !bad_acc && hit_prio &&
		(prio_idx != '0));
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_cnt_q[IDX_W-1:0] : prio_idx;
	assign ram_wdata = (state_q == ST_CLEAR) ? 32'd0 : data_q;
	assign ram_raddr = (state_q == ST_SCAN) ? scan_addr : prio_idx;

	assign scan_start = (state_q == ST_EXEC) && (mode_q == pic_pkg::MODE_EVAL) && ctx_ok;
	assign scan_bits.claimed = claimed_q[ev_ctx][scan_idx];
	assign scan_bits.enabled = en_q[ev_ctx][scan_idx];
	assign scan_bits.pending = pend_q[scan_idx];

	pic_ram #(
		.WIDTH (32),
		.DEPTH (NUM_SOURCES)
	) u_prio_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	pic_scan #(
		.NUM_SOURCES (NUM_SOURCES)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (scan_start),
		.threshold (thr_q[ev_ctx]),
		.prio      (ram_rdata),
		.bits      (scan_bits),
		.ram_addr  (scan_addr),
		.idx       (scan_idx),
		.stat      (scan_stat),
		.best      (scan_best)
	);

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && req.valid) begin
			mode_q  <= req.mode;
			addr_q  <= req.address;
			width_q <= req.access_width;
			data_q  <= req.write_data;
			src_q   <= req.source_id;
			ctxin_q <= req.context_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			pend_q    <= '0;
			en_q      <= '0;
			claimed_q <= '0;
			thr_q     <= '0;
			claim_q   <= '0;
			res_rd_q  <= '0;
			res_st_q  <= 1'b0;
			res_irq_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + CNT_W'(1);
					if (clr_cnt_q == CNT_W'(NUM_SOURCES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req.valid) begin
						res_rd_q  <= '0;
						res_st_q  <= 1'b0;
						res_irq_q <= 1'b0;
						state_q   <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_DONE;
					unique case (pic_pkg::mode_t'(mode_q))
						pic_pkg::MODE_READ, pic_pkg::MODE_WRITE: begin
							priority if (bad_acc) begin
								res_st_q <= 1'b1;
							end else if (hit_prio) begin
								// The priority RAM write port handles the store.
								if (is_read) begin
									state_q <= ST_PRIO;
								end
							end else if (hit_pend) begin
								if (is_read) begin
									res_rd_q <= pend_q[32*pend_w +: 32];
								end else begin
									pend_q[32*pend_w +: 32] <=
										(pend_q[32*pend_w +: 32] & ~pend_mask) |
										(data_q & pend_mask);
								end
							end else if (hit_en) begin
								if (is_read) begin
									res_rd_q <= en_q[en_ctx][32*en_w +: 32];
								end else begin
									en_q[en_ctx][32*en_w +: 32] <=
										(en_q[en_ctx][32*en_w +: 32] & ~en_mask) |
										(data_q & en_mask);
								end
							end else if (hit_thr) begin
								if (is_read) begin
									res_rd_q <= thr_q[pg_ctx];
								end else begin
									thr_q[pg_ctx] <= data_q;
								end
							end else if (hit_claim) begin
								if (is_read) begin
									res_rd_q <= cv;
									if (cv_ok && pend_q[cv[IDX_W-1:0]]) begin
										claimed_q[pg_ctx][cv[IDX_W-1:0]] <= 1'b1;
									end
								end else begin
									claim_q[pg_ctx] <= data_q;
									if (d_ok) begin
										claimed_q[pg_ctx][data_q[IDX_W-1:0]] <= 1'b0;
									end
								end
							end
						end
						pic_pkg::MODE_RAISE: begin
							res_st_q <= raise_bad;
							if (!raise_bad) begin
								pend_q[src_i] <= 1'b1;
							end
						end
						pic_pkg::MODE_EVAL: begin
							if (ctx_ok) begin
								state_q <= ST_SCAN;
							end
						end
					endcase
				end
				ST_PRIO: begin
					res_rd_q <= ram_rdata;
					state_q  <= ST_DONE;
				end
				ST_SCAN: begin
					if (scan_stat.clr_pend) begin
						pend_q[scan_idx] <= 1'b0;
					end
					if (scan_stat.done) begin
						claim_q[ev_ctx] <= 32'(scan_best);
						res_irq_q       <= (scan_best != '0);
						state_q         <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			out_rd_q  <= res_rd_q;
			out_st_q  <= res_st_q;
			out_irq_q <= res_irq_q;
		end
	end

	assign req.ready         = (state_q == ST_IDLE);
	assign rsp.valid         = out_vld_q;
	assign rsp.read_data     = out_rd_q;
	assign rsp.status        = out_st_q;
	assign rsp.interrupt_out = out_irq_q;

endmodule

// ===== rtl/pic_checker.sv =====
// Port-level checks of the interrupt controller and their binding.
module pic_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] rsp_read_data,
	input logic        rsp_status,
	input logic        rsp_interrupt_out
);

	// A response holds until the receiver takes it.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped before it was taken");

	// Only one request is in work at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in work");

	// An evaluation that found a source reports no read data and no error.
	a_irq_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_interrupt_out |-> !rsp_status && (rsp_read_data == 32'd0))
		else $error("interrupt reported together with read data or error");

endmodule

bind platform_interrupt_controller pic_checker u_pic_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_read_data     (rsp.read_data),
	.rsp_status        (rsp.status),
	.rsp_interrupt_out (rsp.interrupt_out)
);

// ===== tb/tb_pic_if_note.sv =====
// Testbench helper types for the interrupt controller checks.
`timescale 1ns / 100ps
package tb_pic_types;
	typedef struct packed {
		logic [31:0] read_data;
		logic        status;
		logic        interrupt_out;
	} pic_result_t;
endpackage

// ===== tb/tb_top.sv =====
// Self-checking testbench of the interrupt controller with a behavioral predictor.
`timescale 1ns / 100ps
module tb_top;
	import pic_pkg::*;
	import tb_pic_types::*;

	localparam int NSRC = 64;
	localparam int NCTX = 2;
	localparam int NW = NSRC / 32;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	pic_req_if req ();
	pic_rsp_if rsp ();

	platform_interrupt_controller dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	// Predicted controller state.
	logic [31:0] prio_m [NSRC];
	logic [31:0] pend_m [NW];
	logic [31:0] en_m [NCTX*NW];
	logic [31:0] thr_m [NCTX];
	logic [31:0] claim_m [NCTX];
	logic [31:0] clmd_m [NCTX*NW];

	pic_result_t expected_results [$];
	int errors = 0;
	longint cycles = 0;
	bit rx_stall_on = 1;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic bit bit_at(input logic [31:0] w0, input logic [31:0] w1, input int n);
		logic [63:0] v;
		v = {w1, w0};
		return v[n];
	endfunction

	function automatic pic_result_t predict_controller(input mode_t m, input logic [31:0] a,
		input logic [3:0] wd, input logic [31:0] d, input logic [5:0] s, input logic c);
		pic_result_t r;
		logic [31:0] wmask;
		logic [31:0] v;
		int kind, idx, cx, best;
		logic [31:0] high;
		bit any_claim;
		r = '0;
		kind = 0; idx = 0; cx = 0; wmask = '1;
		if (m == MODE_READ || m == MODE_WRITE) begin
			if (wd != ACCESS_BYTES || a >= ADDR_LIMIT) begin
				r.status = 1;
			end else begin
				if (a < NSRC*4) begin
					kind = 1; idx = a >> 2;
					if (idx == 0) wmask = 0;
				end else if (a >= PEND_BASE && a < PEND_BASE + NSRC/8) begin
					kind = 2; idx = (a - PEND_BASE) >> 2;
					if (idx == 0) wmask = ~32'd1;
				end else if (a >= EN_BASE && a < EN_BASE + EN_STRIDE*NCTX) begin
					cx = (a - EN_BASE) >> 7;
					if (((a - EN_BASE) & 32'h7F) < NSRC/8) begin
						kind = 3; idx = cx*NW + (((a - EN_BASE) & 32'h7F) >> 2);
						if ((((a - EN_BASE) & 32'h7F) >> 2) == 0) wmask = ~32'd1;
					end
				end else if (a[31:12] >= CTX_PAGE_BASE && a[31:12] < CTX_PAGE_BASE + NCTX) begin
					cx = a[31:12] - CTX_PAGE_BASE;
					if (a[11:0] == THR_OFF) kind = 4;
					else if (a[11:0] == CLAIM_OFF) begin
						kind = 5;
						v = claim_m[cx];
						if (m == MODE_READ) begin
							if (v < NSRC && bit_at(pend_m[0], pend_m[1], v))
								clmd_m[cx*NW + v/32][v%32] = 1;
						end else if (d < NSRC) begin
							clmd_m[cx*NW + d/32][d%32] = 0;
						end
					end
				end
				if (m == MODE_READ) begin
					case (kind)
						1: r.read_data = prio_m[idx];
						2: r.read_data = pend_m[idx];
						3: r.read_data = en_m[idx];
						4: r.read_data = thr_m[cx];
						5: r.read_data = claim_m[cx];
						default: r.read_data = 0;
					endcase
				end else begin
					case (kind)
						1: prio_m[idx] = (prio_m[idx] & ~wmask) | (d & wmask);
						2: pend_m[idx] = (pend_m[idx] & ~wmask) | (d & wmask);
						3: en_m[idx] = (en_m[idx] & ~wmask) | (d & wmask);
						4: thr_m[cx] = d;
						5: claim_m[cx] = d;
						default: ;
					endcase
				end
			end
		end else if (m == MODE_RAISE) begin
			any_claim = 0;
			for (int k = 0; k < NCTX; k++)
				if (bit_at(clmd_m[k*NW], clmd_m[k*NW+1], s)) any_claim = 1;
			if (s == 0 || s >= NSRC || bit_at(pend_m[0], pend_m[1], s) || any_claim)
				r.status = 1;
			else
				pend_m[s/32][s%32] = 1;
		end else begin
			best = 0; high = 0; cx = c;
			for (int k = 0; k < NSRC; k++) begin
				if (bit_at(clmd_m[cx*NW], clmd_m[cx*NW+1], k))
					pend_m[k/32][k%32] = 0;
				else if (bit_at(en_m[cx*NW], en_m[cx*NW+1], k) &&
					bit_at(pend_m[0], pend_m[1], k) && prio_m[k] >= high &&
					prio_m[k] >= thr_m[cx]) begin
					best = k; high = prio_m[k];
				end
			end
			claim_m[cx] = best;
			r.interrupt_out = (best != 0);
		end
		return r;
	endfunction

	// Sends one request; the prediction is made at the accepting edge.
	task automatic send_request(input mode_t m, input logic [31:0] a, input logic [3:0] wd,
		input logic [31:0] d, input logic [5:0] s, input logic c);
		req.valid = 1;
		req.mode = m; req.address = a; req.access_width = wd;
		req.write_data = d; req.source_id = s; req.context_id = c;
		do @(posedge clk); while (!req.ready);
		expected_results.push_back(predict_controller(m, a, wd, d, s, c));
		@(negedge clk);
		req.valid = 0;
	endtask

	task automatic random_gap();
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 12)) @(negedge clk);
	endtask

	task automatic drain();
		while (expected_results.size() != 0) @(negedge clk);
	endtask

	// Receiver stall pattern: while rx_stall_on is set, ready is random; otherwise it stays high.
	always @(negedge clk) begin
		if (!arst_n) rsp.ready <= 0;
		else if (rx_stall_on) rsp.ready <= ($urandom_range(0, 7) > 2);
		else rsp.ready <= 1;
	end

	always @(posedge clk) begin
		pic_result_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: response with no request outstanding: rd=%h st=%b irq=%b",
					$time, rsp.read_data, rsp.status, rsp.interrupt_out);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (rsp.read_data !== want.read_data) begin
					$display("%0t: read_data expected %h actual %h", $time, want.read_data,
						rsp.read_data);
					errors++;
				end
				if (rsp.status !== want.status) begin
					$display("%0t: status expected %b actual %b", $time, want.status, rsp.status);
					errors++;
				end
				if (rsp.interrupt_out !== want.interrupt_out) begin
					$display("%0t: interrupt_out expected %b actual %b", $time,
						want.interrupt_out, rsp.interrupt_out);
					errors++;
				end
			end
		end
	end

	function automatic logic [31:0] random_reg_address();
		logic [31:0] a;
		case ($urandom_range(0, 7))
			0, 1: a = $urandom_range(0, NSRC - 1) * 4 + $urandom_range(0, 3);
			2: a = PEND_BASE + $urandom_range(0, NW - 1) * 4;
			3: a = EN_BASE + $urandom_range(0, NCTX - 1) * EN_STRIDE + $urandom_range(0, 11) * 4;
			4, 5: a = {CTX_PAGE_BASE + 20'($urandom_range(0, NCTX)), 12'h000} +
				($urandom_range(0, 1) ? CLAIM_OFF : THR_OFF);
			6: a = $urandom_range(0, 32'h3FFFFFF);
			default: a = $urandom();
		endcase
		return a;
	endfunction

	task automatic test_directed();
		send_request(MODE_READ, 32'h0, 4'd4, 0, 0, 0);
		send_request(MODE_WRITE, 32'h0, 4'd4, 32'hFFFFFFFF, 0, 0);
		send_request(MODE_READ, 32'h0, 4'd4, 0, 0, 0);
		send_request(MODE_WRITE, 32'h4, 4'd4, 32'hFFFFFFFF, 0, 0);
		send_request(MODE_WRITE, 32'hFC, 4'd4, 32'd7, 0, 0);
		send_request(MODE_READ, 32'hFF, 4'd4, 0, 0, 0);
		send_request(MODE_WRITE, 32'h8, 4'd15, 32'd5, 0, 0);
		send_request(MODE_READ, 32'h0400_0000, 4'd4, 0, 0, 0);
		send_request(MODE_READ, 32'hFFFF_FFFF, 4'd0, 0, 0, 0);
		send_request(MODE_WRITE, PEND_BASE, 4'd4, 32'hFFFFFFFF, 0, 0);
		send_request(MODE_READ, PEND_BASE, 4'd4, 0, 0, 0);
		send_request(MODE_WRITE, EN_BASE, 4'd4, 32'hFFFFFFFF, 0, 0);
		send_request(MODE_WRITE, EN_BASE + 4, 4'd4, 32'hFFFFFFFF, 0, 0);
		send_request(MODE_READ, 32'h3000, 4'd4, 0, 0, 0);
		send_request(MODE_RAISE, 0, 4'd4, 0, 6'd0, 0);
		send_request(MODE_RAISE, 0, 4'd4, 0, 6'd63, 0);
		send_request(MODE_RAISE, 0, 4'd4, 0, 6'd63, 0);
		send_request(MODE_EVAL, 0, 4'd4, 0, 0, 1'b0);
		send_request(MODE_READ, 32'h0020_0004, 4'd4, 0, 0, 0);
		send_request(MODE_RAISE, 0, 4'd4, 0, 6'd63, 0);
		send_request(MODE_EVAL, 0, 4'd4, 0, 0, 1'b1);
		send_request(MODE_WRITE, 32'h0020_0004, 4'd4, 32'd63, 0, 0);
		send_request(MODE_WRITE, 32'h0020_1004, 4'd4, 32'hFFFF_FFFF, 0, 0);
		send_request(MODE_READ, 32'h0020_1004, 4'd4, 0, 0, 0);
		send_request(MODE_WRITE, 32'h0020_1000, 4'd4, 32'hFFFF_FFFF, 0, 0);
	endtask

	// Mostly raise/evaluate/claim/complete flows with random priorities and noise.
	task automatic test_random(input int count);
		int n;
		int burst;
		logic [5:0] s;
		logic c;
		n = 0;
		while (n < count) begin
			burst = $urandom_range(1, 10);
			rx_stall_on = ($urandom_range(0, 3) != 0);
			repeat (burst) begin
				c = $urandom_range(0, 1);
				s = $urandom();
				case ($urandom_range(0, 9))
					0: send_request(MODE_WRITE, s * 4, 4'd4, $urandom_range(0, 7), 0, 0);
					1: send_request(MODE_WRITE, EN_BASE + c * EN_STRIDE + $urandom_range(0, 1) * 4,
						4'd4, $urandom(), 0, 0);
					2, 3: send_request(MODE_RAISE, $urandom(), 4'($urandom()), $urandom(), s, c);
					4, 5: send_request(MODE_EVAL, $urandom(), 4'($urandom()), $urandom(), s, c);
					6: send_request(MODE_READ, {CTX_PAGE_BASE + 20'(c), CLAIM_OFF}, 4'd4, 0, 0, 0);
					7: send_request(MODE_WRITE, {CTX_PAGE_BASE + 20'(c), CLAIM_OFF}, 4'd4,
						($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, NSRC - 1),
						0, 0);
					8: send_request(mode_t'($urandom_range(0, 1)), random_reg_address(),
						($urandom_range(0, 5) == 0) ? 4'($urandom()) : 4'd4,
						($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom(), s, c);
					default: send_request(MODE_WRITE, {CTX_PAGE_BASE + 20'(c), THR_OFF}, 4'd4,
						($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(0, 7), 0, 0);
				endcase
				n++;
			end
			random_gap();
			if ($urandom_range(0, 40) == 0) drain();
		end
	endtask

	initial begin
		for (int k = 0; k < NSRC; k++) prio_m[k] = 0;
		for (int k = 0; k < NW; k++) pend_m[k] = 0;
		for (int k = 0; k < NCTX*NW; k++) begin
			en_m[k] = 0; clmd_m[k] = 0;
		end
		for (int k = 0; k < NCTX; k++) begin
			thr_m[k] = 0; claim_m[k] = 0;
		end
		arst_n = 0;
		req.valid = 0; req.mode = MODE_READ; req.address = 0; req.access_width = 0;
		req.write_data = 0; req.source_id = 0; req.context_id = 0;
		rsp.ready = 0;
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		test_directed();
		drain();
		test_random(430);
		drain();
		repeat (NSRC + 20) @(negedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
